// ----- sv/assert_macros.svh -----
// Assertion helpers used by cba_back.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CBA_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("cba assertion failed");
`define CBA_NEVER(lbl, clk, rst_n, cond) \
    `CBA_ASSERT(lbl, clk, rst_n, !(cond))
`else
`define CBA_ASSERT(lbl, clk, rst_n, prop)
`define CBA_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ----- sv/cba_pkg.sv -----
package cba_pkg;

    localparam int MAX_BLOCKS = 1024;
    localparam int BLK_W      = $clog2(MAX_BLOCKS);
    localparam int CNT_W      = BLK_W + 1;
    localparam int BYTES_W    = 23;
    localparam int LOG2_W     = 5;
    localparam int NEED_W     = 15;
    localparam int SUM_W      = BYTES_W + 1;

    localparam logic [LOG2_W-1:0] BS_LOG2_MIN   = LOG2_W'(9);
    localparam logic [LOG2_W-1:0] BS_LOG2_MAX   = LOG2_W'(16);
    localparam logic [LOG2_W-1:0] BS_LOG2_RESET = LOG2_W'(12);

    // A link at or above this value ends a chain.
    localparam logic [CNT_W-1:0] END_LINK    = CNT_W'(MAX_BLOCKS);
    localparam logic [CNT_W-1:0] LIMIT_RESET = CNT_W'(MAX_BLOCKS);

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BLOCK_SIZE_LOG2 = 1'b0,
        CFG_BLOCKS_LIMIT    = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_SPACE = 2'd1,
        ST_BAD_HEAD = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_ALLOC = 2'd1,
        OP_FREE  = 2'd2
    } op_kind_t;

    typedef struct packed {
        op_kind_t          kind;
        logic [NEED_W-1:0] need;
        logic [BLK_W-1:0]  head;
    } op_t;

    typedef struct packed {
        logic valid;
        op_t  op;
    } op_word_t;

    typedef enum logic [2:0] {
        B_CLEAR = 3'd0,
        B_IDLE  = 3'd1,
        B_SCAN  = 3'd2,
        B_TERM  = 3'd3,
        B_WALK  = 3'd4,
        B_DONE  = 3'd5
    } back_state_t;

endpackage

// ----- sv/cba_if.sv -----
interface cba_req_if import cba_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               cmd;
    logic [BYTES_W-1:0] byte_count;
    logic [BLK_W-1:0]   head_block;

    modport source (output valid, cmd, byte_count, head_block, input ready);
    modport sink   (input valid, cmd, byte_count, head_block, output ready);
endinterface

interface cba_rsp_if import cba_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [1:0]       status;
    logic [BLK_W-1:0] first_block;
    logic [CNT_W-1:0] block_total;
    logic [CNT_W-1:0] free_blocks;

    modport source (output valid, status, first_block, block_total, free_blocks,
                    input ready);
    modport sink   (input valid, status, first_block, block_total, free_blocks,
                    output ready);
endinterface

interface cba_cfg_if import cba_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- sv/cba_front.sv -----
module cba_front import cba_pkg::*;
(
    cba_req_if.sink          req,
    input  logic [LOG2_W-1:0] block_size_log2,
    input  logic              accept_en,
    input  logic              full,
    output op_word_t          push
);

    logic [LOG2_W-1:0] lg;
    logic [SUM_W-1:0]  mask;
    logic [SUM_W-1:0]  sum;
    logic [SUM_W-1:0]  blocks;

    always_comb
    begin
        if (block_size_log2 < BS_LOG2_MIN)
        begin
            lg = BS_LOG2_MIN;
        end
        else if (block_size_log2 > BS_LOG2_MAX)
        begin
            lg = BS_LOG2_MAX;
        end
        else
        begin
            lg = block_size_log2;
        end
    end

    // Round the byte count up to whole blocks.
    assign mask   = (SUM_W'(1) << lg) - SUM_W'(1);
    assign sum    = {1'b0, req.byte_count} + mask;
    assign blocks = sum >> lg;

    assign req.ready = accept_en && !full;

    always_comb
    begin
        push.valid   = req.valid && req.ready;
        push.op.need = blocks[NEED_W-1:0];
        push.op.head = req.head_block;
        if (req.cmd)
        begin
            push.op.kind = OP_FREE;
        end
        else if (req.byte_count == '0)
        begin
            push.op.kind = OP_NONE;
        end
        else
        begin
            push.op.kind = OP_ALLOC;
        end
    end

endmodule

// ----- sv/cba_queue.sv -----
module cba_queue import cba_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  op_word_t push,
    input  logic     pop,
    output op_word_t head,
    output logic     full
);

    op_t                entries_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] cnt_reg, cnt_next;
    logic               do_pop;

    assign do_pop = pop && (cnt_reg != '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push.valid)
        begin
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push.valid && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!push.valid && do_pop)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            entries_reg[wr_ptr_reg] <= push.op;
        end
    end

    assign head.valid = (cnt_reg != '0);
    assign head.op    = entries_reg[rd_ptr_reg];
    assign full       = (cnt_reg == Q_CNT_W'(Q_DEPTH));

endmodule

// ----- sv/cba_back.sv -----
`include "assert_macros.svh"

module cba_back import cba_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  op_word_t         q_head,
    output logic             q_pop,
    output logic             clearing,
    input  logic [CNT_W-1:0] blocks_limit,
    cba_rsp_if.source        rsp
);

    // Block table: used bits and links, one read and one write per cycle each.
    logic             used_mem [MAX_BLOCKS];
    logic [CNT_W-1:0] next_mem [MAX_BLOCKS];

    logic             rd_en;
    logic [BLK_W-1:0] rd_addr;
    logic             used_we;
    logic [BLK_W-1:0] used_wa;
    logic             used_wd;
    logic             next_we;
    logic [BLK_W-1:0] next_wa;
    logic [CNT_W-1:0] next_wd;
    logic             used_rdata_reg;
    logic [CNT_W-1:0] next_rdata_reg;

    back_state_t       state_reg, state_next;
    logic [CNT_W-1:0]  used_count_reg, used_count_next;
    logic [CNT_W-1:0]  scan_addr_reg, scan_addr_next;
    logic              rd_pend_reg, rd_pend_next;
    logic [BLK_W-1:0]  rd_idx_reg, rd_idx_next;
    logic [BLK_W-1:0]  prev_reg, prev_next;
    logic [BLK_W-1:0]  cur_reg, cur_next;
    logic [BLK_W-1:0]  clr_addr_reg, clr_addr_next;
    logic [CNT_W-1:0]  total_reg, total_next;
    logic [NEED_W-1:0] need_reg, need_next;
    logic [BLK_W-1:0]  first_reg, first_next;
    status_t           status_reg, status_next;

    logic              out_valid_reg, out_valid_next;
    status_t           out_status_reg;
    logic [BLK_W-1:0]  out_first_reg;
    logic [CNT_W-1:0]  out_total_reg;
    logic [CNT_W-1:0]  out_free_reg;
    logic              out_load;

    logic [CNT_W-1:0]  eff_limit;
    logic [CNT_W-1:0]  free_cnt;
    logic              claim;
    logic              scan_end;

    assign eff_limit = (blocks_limit > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : blocks_limit;
    assign free_cnt  = (eff_limit > used_count_reg) ? eff_limit - used_count_reg : '0;
    assign clearing  = (state_reg == B_CLEAR);

    always_comb
    begin
        state_next      = state_reg;
        used_count_next = used_count_reg;
        scan_addr_next  = scan_addr_reg;
        rd_pend_next    = rd_pend_reg;
        rd_idx_next     = rd_idx_reg;
        prev_next       = prev_reg;
        cur_next        = cur_reg;
        clr_addr_next   = clr_addr_reg;
        total_next      = total_reg;
        need_next       = need_reg;
        first_next      = first_reg;
        status_next     = status_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_load        = 1'b0;
        q_pop           = 1'b0;
        rd_en           = 1'b0;
        rd_addr         = '0;
        used_we         = 1'b0;
        used_wa         = '0;
        used_wd         = 1'b0;
        next_we         = 1'b0;
        next_wa         = '0;
        next_wd         = END_LINK;
        claim           = 1'b0;
        scan_end        = 1'b0;

        unique case (state_reg)
            B_CLEAR:
            begin
                used_we       = 1'b1;
                used_wa       = clr_addr_reg;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == BLK_W'(MAX_BLOCKS - 1))
                begin
                    state_next = B_IDLE;
                end
            end

            B_IDLE:
            begin
                if (q_head.valid)
                begin
                    q_pop       = 1'b1;
                    total_next  = '0;
                    first_next  = '0;
                    status_next = ST_OK;
                    unique case (q_head.op.kind)
                        OP_ALLOC:
                        begin
                            if (q_head.op.need > NEED_W'(free_cnt))
                            begin
                                status_next = ST_NO_SPACE;
                                state_next  = B_DONE;
                            end
                            else
                            begin
                                need_next      = q_head.op.need;
                                scan_addr_next = '0;
                                rd_pend_next   = 1'b0;
                                state_next     = B_SCAN;
                            end
                        end
                        OP_FREE:
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = q_head.op.head;
                            cur_next   = q_head.op.head;
                            state_next = B_WALK;
                        end
                        default:
                        begin
                            state_next = B_DONE;
                        end
                    endcase
                end
            end

            B_SCAN:
            begin
                // Issue one read ahead; judge the block read last cycle.
                if (scan_addr_reg < eff_limit)
                begin
                    rd_en          = 1'b1;
                    rd_addr        = scan_addr_reg[BLK_W-1:0];
                    scan_addr_next = scan_addr_reg + 1'b1;
                    rd_pend_next   = 1'b1;
                    rd_idx_next    = scan_addr_reg[BLK_W-1:0];
                end
                else
                begin
                    rd_pend_next = 1'b0;
                end
                claim = rd_pend_reg && !used_rdata_reg && (NEED_W'(total_reg) < need_reg);
                if (claim)
                begin
                    used_we = 1'b1;
                    used_wa = rd_idx_reg;
                    used_wd = 1'b1;
                    if (total_reg == '0)
                    begin
                        first_next = rd_idx_reg;
                    end
                    else
                    begin
                        next_we = 1'b1;
                        next_wa = prev_reg;
                        next_wd = {1'b0, rd_idx_reg};
                    end
                    prev_next       = rd_idx_reg;
                    total_next      = total_reg + 1'b1;
                    used_count_next = used_count_reg + 1'b1;
                end
                scan_end = (claim && (NEED_W'(total_reg) + 1'b1 == need_reg))
                           || (!rd_pend_reg && (scan_addr_reg >= eff_limit));
                if (scan_end)
                begin
                    state_next = (total_next == '0) ? B_DONE : B_TERM;
                end
            end

            B_TERM:
            begin
                next_we    = 1'b1;
                next_wa    = prev_reg;
                next_wd    = END_LINK;
                state_next = B_DONE;
            end

            B_WALK:
            begin
                if (used_rdata_reg)
                begin
                    used_we    = 1'b1;
                    used_wa    = cur_reg;
                    used_wd    = 1'b0;
                    total_next = total_reg + 1'b1;
                    if (used_count_reg != '0)
                    begin
                        used_count_next = used_count_reg - 1'b1;
                    end
                    // Links only point upward, so the next read never hits this write.
                    if (next_rdata_reg < END_LINK)
                    begin
                        rd_en    = 1'b1;
                        rd_addr  = next_rdata_reg[BLK_W-1:0];
                        cur_next = next_rdata_reg[BLK_W-1:0];
                    end
                    else
                    begin
                        state_next = B_DONE;
                    end
                end
                else
                begin
                    if (total_reg == '0)
                    begin
                        status_next = ST_BAD_HEAD;
                    end
                    state_next = B_DONE;
                end
            end

            B_DONE:
            begin
                // Hold until the output register is free.
                if (!out_valid_reg || rsp.ready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = B_IDLE;
                end
            end

            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (used_we)
        begin
            used_mem[used_wa] <= used_wd;
        end
        if (rd_en)
        begin
            used_rdata_reg <= used_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (next_we)
        begin
            next_mem[next_wa] <= next_wd;
        end
        if (rd_en)
        begin
            next_rdata_reg <= next_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= B_CLEAR;
            used_count_reg <= '0;
            clr_addr_reg   <= '0;
            rd_pend_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            used_count_reg <= used_count_next;
            clr_addr_reg   <= clr_addr_next;
            rd_pend_reg    <= rd_pend_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_addr_reg <= scan_addr_next;
        rd_idx_reg    <= rd_idx_next;
        prev_reg      <= prev_next;
        cur_reg       <= cur_next;
        total_reg     <= total_next;
        need_reg      <= need_next;
        first_reg     <= first_next;
        status_reg    <= status_next;
        if (out_load)
        begin
            out_status_reg <= status_reg;
            out_first_reg  <= first_reg;
            out_total_reg  <= total_reg;
            out_free_reg   <= free_cnt;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.first_block = out_first_reg;
    assign rsp.block_total = out_total_reg;
    assign rsp.free_blocks = out_free_reg;

    `CBA_NEVER(a_used_bound, clk, rst_n, used_count_reg > CNT_W'(MAX_BLOCKS))
    `CBA_NEVER(a_scan_over, clk, rst_n, state_reg == B_SCAN && NEED_W'(total_reg) > need_reg)
    `CBA_ASSERT(a_walk_up, clk, rst_n, (state_reg == B_WALK && $past(state_reg) == B_WALK && cur_reg != $past(cur_reg)) |-> cur_reg > $past(cur_reg))
    `CBA_ASSERT(a_load_from_done, clk, rst_n, $rose(out_valid_reg) |-> $past(state_reg) == B_DONE)
    `CBA_NEVER(a_no_word_in_clear, clk, rst_n, state_reg == B_CLEAR && q_head.valid)

endmodule

// ----- sv/chained_block_allocator.sv -----
// Channel  Modport  Payload                                             Accepted when
// cfg      sink     index, data                                         valid && ready
// req      sink     cmd, byte_count, head_block                         valid && ready
// rsp      source   status, first_block, block_total, free_blocks       valid && ready
//
// Allocate: scans the used bits in table order up to the last block claimed (at most the
// blocks limit), one read at a time through the single read port of the used-bit memory,
// then writes the end link. Free: walks the chain, clearing each used bit in turn.
// Refused or zero-byte allocations go straight to the result.
// After reset a pass clears all 1024 used bits; req.ready stays low until it ends.
// A two-word queue takes requests while a command runs; a result waits in the output register.
module chained_block_allocator import cba_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    cba_cfg_if.sink    cfg,
    cba_req_if.sink    req,
    cba_rsp_if.source  rsp
);

    logic [LOG2_W-1:0] bs_log2_reg;
    logic [CNT_W-1:0]  limit_reg;
    op_word_t          push;
    op_word_t          q_head;
    logic              q_full;
    logic              q_pop;
    logic              clearing;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bs_log2_reg <= BS_LOG2_RESET;
            limit_reg   <= LIMIT_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg_index_t'(cfg.index))
                CFG_BLOCK_SIZE_LOG2: bs_log2_reg <= cfg.data[LOG2_W-1:0];
                CFG_BLOCKS_LIMIT:    limit_reg   <= cfg.data[CNT_W-1:0];
                default:             limit_reg   <= limit_reg;
            endcase
        end
    end

    cba_front u_front
    (
        .req             (req),
        .block_size_log2 (bs_log2_reg),
        .accept_en       (!clearing),
        .full            (q_full),
        .push            (push)
    );

    cba_queue u_queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (q_pop),
        .head  (q_head),
        .full  (q_full)
    );

    cba_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .clearing     (clearing),
        .blocks_limit (limit_reg),
        .rsp          (rsp)
    );

endmodule
